// ----- src/u16u8_pkg.sv -----
// shared types, constants and the utf-8 byte builder for the utf-16 to utf-8 transcoder
// no dependencies; imported by every module of the block
package u16u8_pkg;

	// result status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_TRUNC_DATA  = 2'd1;
	localparam logic [1:0] ST_TRUNC_SURR  = 2'd2;
	localparam logic [1:0] ST_BAD_SURR    = 2'd3;

	// stream start tracking codes
	localparam logic [1:0] START_IDLE = 2'd0;
	localparam logic [1:0] START_ONE  = 2'd1;
	localparam logic [1:0] START_PAST = 2'd2;

	// byte order mark bytes
	localparam logic [7:0] BOM_FF = 8'hff;
	localparam logic [7:0] BOM_FE = 8'hfe;

	// top six bits of a surrogate code unit
	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	// supplementary plane offset, added to the ten high payload bits that sit above the ten low ones
	localparam logic [10:0] SUPP_OFFSET = 11'h040;

	// utf-8 lengths minus one
	localparam logic [1:0] LEN_1 = 2'd0;
	localparam logic [1:0] LEN_2 = 2'd1;
	localparam logic [1:0] LEN_3 = 2'd2;
	localparam logic [1:0] LEN_4 = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one job handed from the front to the back
	typedef struct packed {
		logic [20:0] cp;
		logic [1:0]  len_m1;
		logic        is_status;
		logic [1:0]  status;
		logic        done;
	} job_t;

	// byte number idx of the utf-8 form of cp
	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
		input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (len_m1)
			LEN_1: b = {1'b0, cp[6:0]};
			LEN_2: begin
				if (idx == 2'd0) b = {3'b110, cp[10:6]};
				else             b = {2'b10, cp[5:0]};
			end
			LEN_3: begin
				unique case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				unique case (idx)
					2'd0: b = {5'b11110, cp[20:18]};
					2'd1: b = {2'b10, cp[17:12]};
					2'd2: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

// ----- src/u16u8_front.sv -----
// front part: byte pairing, byte order mark, surrogate joining and error tracking
// depends on u16u8_pkg; pushes one job per input byte that causes any result
module u16u8_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // in_byte
	input  logic              s_tlast,   // in_last
	input  logic              queue_full,
	output logic              push,
	output u16u8_pkg::job_t   push_job
);
	import u16u8_pkg::*;

	logic [1:0]  start_q, start_n;
	logic [7:0]  held_q, held_n;
	logic        byte_held_q, byte_held_n;
	logic        big_q, big_n;
	logic [9:0]  hbits_q, hbits_n;
	logic        hp_q, hp_n;
	logic        failed_q, failed_n;
	logic [1:0]  fcode_q, fcode_n;

	assign s_tready = !queue_full;

	// per-byte decode and next state
	always_comb begin
		logic        acc;
		logic        mark;
		logic [15:0] u;
		logic        is_high;
		logic        is_low;
		logic [1:0]  code;
		logic [20:0] cp;
		acc         = s_tvalid && s_tready;
		mark        = 1'b0;
		u           = big_q ? {held_q, s_tdata} : {s_tdata, held_q};
		is_high     = (u[15:10] == HIGH_SURR_TAG);
		is_low      = (u[15:10] == LOW_SURR_TAG);
		code        = ST_OK;
		cp          = {5'd0, u};
		start_n     = start_q;
		held_n      = held_q;
		byte_held_n = byte_held_q;
		big_n       = big_q;
		hbits_n     = hbits_q;
		hp_n        = hp_q;
		failed_n    = failed_q;
		fcode_n     = fcode_q;
		push        = 1'b0;
		push_job    = '0;
		if (acc) begin
			if (!failed_q) begin
				if (!byte_held_q) begin
					held_n      = s_tdata;
					byte_held_n = 1'b1;
					if (start_q == START_IDLE) start_n = START_ONE;
				end else begin
					byte_held_n = 1'b0;
					if (start_q == START_ONE) begin
						start_n = START_PAST;
						if (held_q == BOM_FF && s_tdata == BOM_FE) begin
							mark = 1'b1;
						end else if (held_q == BOM_FE && s_tdata == BOM_FF) begin
							big_n = 1'b1;
							mark  = 1'b1;
						end
					end
					if (!mark) begin
						priority if (hp_q) begin
							hp_n    = 1'b0;
							hbits_n = '0;
							if (is_low) begin
								cp                 = {{1'b0, hbits_q} + SUPP_OFFSET, u[9:0]};
								push               = 1'b1;
								push_job.cp        = cp;
							end else begin
								failed_n           = 1'b1;
								fcode_n            = ST_BAD_SURR;
								push               = 1'b1;
								push_job.is_status = 1'b1;
								push_job.status    = ST_BAD_SURR;
							end
						end else if (is_high) begin
							hbits_n = u[9:0];
							hp_n    = 1'b1;
						end else if (is_low) begin
							failed_n           = 1'b1;
							fcode_n            = ST_BAD_SURR;
							push               = 1'b1;
							push_job.is_status = 1'b1;
							push_job.status    = ST_BAD_SURR;
						end else begin
							push        = 1'b1;
							push_job.cp = cp;
						end
					end
				end
			end
			// utf-8 length of a data job
			priority if (push_job.cp[20:7] == '0)  push_job.len_m1 = LEN_1;
			else if (push_job.cp[20:11] == '0)     push_job.len_m1 = LEN_2;
			else if (push_job.cp[20:16] == '0)     push_job.len_m1 = LEN_3;
			else                                   push_job.len_m1 = LEN_4;
			// stream end: final status and return to reset state
			if (s_tlast) begin
				if (failed_n) begin
					if (failed_q || !push) begin
						push_job           = '0;
						push_job.is_status = 1'b1;
						push_job.status    = fcode_n;
					end
				end else begin
					code = byte_held_n ? ST_TRUNC_DATA : (hp_n ? ST_TRUNC_SURR : ST_OK);
					if (code != ST_OK || !push) begin
						push_job           = '0;
						push_job.is_status = 1'b1;
						push_job.status    = code;
					end
				end
				push          = 1'b1;
				push_job.done = 1'b1;
				start_n       = START_IDLE;
				held_n        = '0;
				byte_held_n   = 1'b0;
				big_n         = 1'b0;
				hbits_n       = '0;
				hp_n          = 1'b0;
				failed_n      = 1'b0;
				fcode_n       = ST_OK;
			end
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= START_IDLE;
			held_q      <= '0;
			byte_held_q <= 1'b0;
			big_q       <= 1'b0;
			hbits_q     <= '0;
			hp_q        <= 1'b0;
			failed_q    <= 1'b0;
			fcode_q     <= ST_OK;
		end else begin
			start_q     <= start_n;
			held_q      <= held_n;
			byte_held_q <= byte_held_n;
			big_q       <= big_n;
			hbits_q     <= hbits_n;
			hp_q        <= hp_n;
			failed_q    <= failed_n;
			fcode_q     <= fcode_n;
		end
	end

endmodule

// ----- src/u16u8_queue.sv -----
// short job queue between the front and the back
// depends on u16u8_pkg for job_t and the queue depth
module u16u8_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u16u8_pkg::job_t   push_job,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output u16u8_pkg::job_t   head_job
);
	import u16u8_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	localparam logic [QPTR_W:0] DEPTH_CNT = QUEUE_DEPTH[QPTR_W:0];

	assign full       = (count_q == DEPTH_CNT);
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/u16u8_back.sv -----
// back part: expands each job into utf-8 bytes or one status word
// depends on u16u8_pkg; drives the registered output channel
module u16u8_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  u16u8_pkg::job_t   head_job,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // out_byte
	output logic              m_tlast,   // stream_done
	output logic [3:0]        m_tuser    // byte_valid, run_last, status[1:0]
);
	import u16u8_pkg::*;

	logic [1:0] idx_q;
	logic       load;
	logic       job_end;

	// last word of the current job
	assign job_end = head_job.is_status || (idx_q == head_job.len_m1);
	assign load    = head_valid && (!m_tvalid || m_tready);
	assign pop     = load && job_end;

	// byte position within the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= job_end ? 2'd0 : idx_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata    <= head_job.is_status ? 8'h00
				: utf8_byte(head_job.cp, head_job.len_m1, idx_q);
			m_tuser[0] <= !head_job.is_status;
			m_tuser[1] <= job_end;
			m_tuser[3:2] <= head_job.is_status ? head_job.status : ST_OK;
			m_tlast    <= job_end && head_job.done;
		end
	end

endmodule

// ----- src/utf16_to_utf8_transcoder.sv -----
// channel  dir  tdata        tuser                                tlast
// s_*      in   in_byte      -                                    in_last
// m_*      out  out_byte     byte_valid, run_last, status[1:0]    stream_done
//
// an input byte is taken whenever the job queue has room; the back end, with its
// single-word output port, sends one result per cycle unless the output stalls.
// reset clears all stream state and the queue at once; there is no clearing pass.
// output stalls fill the four-entry queue and only then hold off input.
module utf16_to_utf8_transcoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast,   // stream_done
	output logic [3:0] m_tuser    // byte_valid, run_last, status[1:0]
);
	import u16u8_pkg::*;

	logic queue_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	// decode
	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	// job queue
	u16u8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// encode
	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
